FILE: design/csmabo_pkg.sv
// Shared types, codes and constants for the slotted CSMA-CA backoff unit.
package csmabo_pkg;

    // Input opcodes
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    // Result actions
    localparam logic [1:0] ACT_NONE = 2'd0;
    localparam logic [1:0] ACT_TX   = 2'd1;
    localparam logic [1:0] ACT_FAIL = 2'd2;

    // CSMA phases (code 3 behaves as init)
    localparam logic [1:0] PH_INIT  = 2'd0;
    localparam logic [1:0] PH_DELAY = 2'd1;
    localparam logic [1:0] PH_CCA   = 2'd2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_BE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_NB   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BLE      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SIFS     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LIFS     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_OVH  = 3'd7;
    localparam int CFG_DATA_W = 16;

    // Reset values of the configuration registers
    localparam logic [3:0] MIN_BE_RST = 4'd3;
    localparam logic [3:0] MAX_BE_RST = 4'd5;
    localparam logic [3:0] MAX_NB_RST = 4'd4;

    // Contention window start value and BE cap in battery-life mode
    localparam logic [1:0] CW_INIT = 2'd2;
    localparam logic [3:0] BLE_BE  = 4'd2;

    // Field widths
    localparam int BUDGET_W = 32;
    localparam int LEN_W    = 7;
    localparam int RND_W    = 8;
    localparam int NEED_W   = 18;  // 2*127 + two 16-bit terms
    localparam int REM_W    = 16;
    localparam int DIV_CNT_W = $clog2(RND_W);

    localparam int MAX_SIFS_FRAME_DEF = 18;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BUDGET,
        ST_DECIDE,
        ST_DIVIDE,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic load_in;     // latch the input item
        logic upd_budget;  // budget update and frame need
        logic commit;      // commit CSMA decision, arm divider
        logic div_step;    // one remainder bit
        logic push;        // finish delay draw, load result register
    } t_cmd;

    typedef struct packed {
        logic draw;        // decision needs a random delay
        logic div_last;    // last divider step
        logic out_free;    // result register can take a new item
    } t_sts;

endpackage

FILE: design/csmabo_ctrl.sv
// Sequencing state machine of the CSMA-CA backoff unit.
module csmabo_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  csmabo_pkg::t_sts    i_sts,
    output csmabo_pkg::t_cmd    o_cmd,
    output logic                o_busy
);

    csmabo_pkg::t_state r_state;
    csmabo_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= csmabo_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        case (r_state)
            csmabo_pkg::ST_IDLE: begin
                o_busy = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = csmabo_pkg::ST_BUDGET;
                end
            end
            csmabo_pkg::ST_BUDGET: begin
                o_cmd.upd_budget = 1'b1;
                n_state = csmabo_pkg::ST_DECIDE;
            end
            csmabo_pkg::ST_DECIDE: begin
                o_cmd.commit = 1'b1;
                n_state = i_sts.draw ? csmabo_pkg::ST_DIVIDE : csmabo_pkg::ST_FINISH;
            end
            csmabo_pkg::ST_DIVIDE: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = csmabo_pkg::ST_FINISH;
                end
            end
            csmabo_pkg::ST_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state = csmabo_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = csmabo_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: design/csmabo_dp.sv
// Datapath: configuration, CSMA state, budget, remainder unit, result register.
module csmabo_dp #(
    parameter int MAX_SIFS_FRAME = csmabo_pkg::MAX_SIFS_FRAME_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [csmabo_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [csmabo_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                  i_opcode,
    input  logic [csmabo_pkg::BUDGET_W-1:0]       i_cap_budget,
    input  logic                                  i_in_cap,
    input  logic                                  i_queue_nonempty,
    input  logic [csmabo_pkg::LEN_W-1:0]          i_frame_len,
    input  logic                                  i_ack_request,
    input  logic                                  i_channel_clear,
    input  logic [csmabo_pkg::RND_W-1:0]          i_random_byte,
    input  logic                                  i_out_stall,
    input  csmabo_pkg::t_cmd                      i_cmd,
    output csmabo_pkg::t_sts                      o_sts,
    output logic                                  o_out_valid,
    output logic [1:0]                            o_action,
    output logic [csmabo_pkg::BUDGET_W-1:0]       o_budget_left
);

    localparam logic [csmabo_pkg::LEN_W-1:0] SifsLim = csmabo_pkg::LEN_W'(MAX_SIFS_FRAME);

    // configuration
    logic [3:0]  r_min_be, r_max_be, r_max_nb;
    logic        r_ble;
    logic [15:0] r_sifs, r_lifs, r_tick, r_ack_ovh;

    // CSMA state
    logic [1:0]  r_phase;
    logic [3:0]  r_nb, r_be;
    logic [1:0]  r_cw;
    logic [7:0]  r_delay;
    logic [csmabo_pkg::BUDGET_W-1:0] r_budget;

    // latched item
    logic        r_op, r_in_cap, r_queue, r_ack, r_clear;
    logic [csmabo_pkg::LEN_W-1:0]    r_len;
    logic [csmabo_pkg::BUDGET_W-1:0] r_cap_budget;
    logic [csmabo_pkg::RND_W-1:0]    r_rnd;
    logic [csmabo_pkg::NEED_W-1:0]   r_need;

    // pending decision
    logic        r_draw;
    logic [1:0]  r_act;

    // remainder unit
    logic [csmabo_pkg::REM_W-1:0]     r_rem;
    logic [csmabo_pkg::DIV_CNT_W-1:0] r_div_cnt;
    logic [csmabo_pkg::REM_W-1:0]     w_mod, w_trial;

    // decision
    logic        w_tick, w_fits, w_run;
    logic [1:0]  d_phase, d_cw, d_act;
    logic [3:0]  d_nb, d_be;
    logic        d_draw, d_dec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_be  <= csmabo_pkg::MIN_BE_RST;
            r_max_be  <= csmabo_pkg::MAX_BE_RST;
            r_max_nb  <= csmabo_pkg::MAX_NB_RST;
            r_ble     <= 1'b0;
            r_sifs    <= '0;
            r_lifs    <= '0;
            r_tick    <= '0;
            r_ack_ovh <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                csmabo_pkg::CFG_MIN_BE:  r_min_be  <= i_cfg_data[3:0];
                csmabo_pkg::CFG_MAX_BE:  r_max_be  <= i_cfg_data[3:0];
                csmabo_pkg::CFG_MAX_NB:  r_max_nb  <= i_cfg_data[3:0];
                csmabo_pkg::CFG_BLE:     r_ble     <= i_cfg_data[0];
                csmabo_pkg::CFG_SIFS:    r_sifs    <= i_cfg_data;
                csmabo_pkg::CFG_LIFS:    r_lifs    <= i_cfg_data;
                csmabo_pkg::CFG_TICK:    r_tick    <= i_cfg_data;
                csmabo_pkg::CFG_ACK_OVH: r_ack_ovh <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // item latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op         <= i_opcode;
            r_cap_budget <= i_cap_budget;
            r_in_cap     <= i_in_cap;
            r_queue      <= i_queue_nonempty;
            r_len        <= i_frame_len;
            r_ack        <= i_ack_request;
            r_clear      <= i_channel_clear;
        end
        if (i_cmd.upd_budget) begin
            r_need <= csmabo_pkg::NEED_W'({r_len, 1'b0})
                    + (r_ack ? csmabo_pkg::NEED_W'(r_ack_ovh) : '0)
                    + csmabo_pkg::NEED_W'((r_len < SifsLim) ? r_sifs : r_lifs);
        end
    end

    assign w_tick = (r_op == csmabo_pkg::OP_TICK) && r_in_cap;
    assign w_fits = {{(csmabo_pkg::BUDGET_W-csmabo_pkg::NEED_W){1'b0}}, r_need} <= r_budget;

    always_comb begin
        d_phase = r_phase;
        d_nb    = r_nb;
        d_be    = r_be;
        d_cw    = r_cw;
        d_act   = csmabo_pkg::ACT_NONE;
        d_draw  = 1'b0;
        d_dec   = 1'b0;
        w_run   = 1'b0;
        if (w_tick) begin
            case (r_phase)
                csmabo_pkg::PH_DELAY: begin
                    if (r_delay == 8'd0) begin
                        if (w_fits) begin
                            d_phase = csmabo_pkg::PH_CCA;
                            w_run   = 1'b1;
                        end else begin
                            d_draw = 1'b1;
                        end
                    end else begin
                        d_dec = 1'b1;
                    end
                end
                csmabo_pkg::PH_CCA: begin
                    w_run = 1'b1;
                end
                default: begin
                    if (r_queue) begin
                        d_nb    = 4'd0;
                        d_cw    = csmabo_pkg::CW_INIT;
                        d_be    = (r_ble && (r_min_be > csmabo_pkg::BLE_BE))
                                  ? csmabo_pkg::BLE_BE : r_min_be;
                        d_draw  = 1'b1;
                        d_phase = csmabo_pkg::PH_DELAY;
                    end
                end
            endcase
            if (w_run) begin
                if (!r_clear) begin
                    d_cw = csmabo_pkg::CW_INIT;
                    if (r_nb > r_max_nb) begin
                        d_act   = csmabo_pkg::ACT_FAIL;
                        d_phase = csmabo_pkg::PH_INIT;
                    end else begin
                        d_nb = r_nb + 4'd1;
                        if (r_be < r_max_be) begin
                            d_be = r_be + 4'd1;
                        end
                        d_draw  = 1'b1;
                        d_phase = csmabo_pkg::PH_DELAY;
                    end
                end else begin
                    d_cw = r_cw - 2'd1;
                    if (d_cw == 2'd0) begin
                        d_act   = csmabo_pkg::ACT_TX;
                        d_phase = csmabo_pkg::PH_INIT;
                    end
                end
            end
        end
    end

    // restoring remainder, one dividend bit per step
    assign w_mod   = (csmabo_pkg::REM_W'(1) << r_be) - csmabo_pkg::REM_W'(1);
    assign w_trial = {r_rem[csmabo_pkg::REM_W-2:0], r_rnd[csmabo_pkg::RND_W-1]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_rnd <= i_random_byte;
        end else if (i_cmd.div_step) begin
            r_rnd <= {r_rnd[csmabo_pkg::RND_W-2:0], 1'b0};
        end
        if (i_cmd.commit) begin
            r_rem     <= '0;
            r_div_cnt <= '0;
            r_draw    <= d_draw;
            r_act     <= d_act;
        end else if (i_cmd.div_step) begin
            r_rem     <= (w_trial >= w_mod) ? (w_trial - w_mod) : w_trial;
            r_div_cnt <= r_div_cnt + csmabo_pkg::DIV_CNT_W'(1);
        end
    end

    // CSMA state and budget
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= csmabo_pkg::PH_INIT;
            r_nb     <= '0;
            r_be     <= '0;
            r_cw     <= '0;
            r_delay  <= '0;
            r_budget <= '0;
        end else begin
            if (i_cmd.upd_budget) begin
                if (r_op == csmabo_pkg::OP_LOAD) begin
                    r_budget <= r_cap_budget;
                end else if (r_in_cap && (r_budget >= csmabo_pkg::BUDGET_W'(r_tick))) begin
                    r_budget <= r_budget - csmabo_pkg::BUDGET_W'(r_tick);
                end
            end
            if (i_cmd.commit) begin
                r_phase <= d_phase;
                r_nb    <= d_nb;
                r_be    <= d_be;
                r_cw    <= d_cw;
                if (d_dec) begin
                    r_delay <= r_delay - 8'd1;
                end
            end
            if (i_cmd.push && r_draw) begin
                r_delay <= (r_be <= 4'd1) ? 8'd0 : r_rem[7:0];
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            o_action      <= r_act;
            o_budget_left <= r_budget;
        end
    end

    assign o_sts.draw     = d_draw;
    assign o_sts.div_last = (r_div_cnt == csmabo_pkg::DIV_CNT_W'(csmabo_pkg::RND_W - 1));
    assign o_sts.out_free = !o_out_valid || !i_out_stall;

endmodule

FILE: design/slotted_csma_ca_backoff_unit.sv
// Top level of the slotted CSMA-CA backoff unit.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------------------
//  input   | in        | i_valid / o_stall    | opcode, cap_budget, in_cap, queue_nonempty,
//          |           |                      | frame_len, ack_request, channel_clear,
//          |           |                      | random_byte
//  result  | out       | o_valid / i_stall    | action, budget_left
//  config  | in        | i_cfg_we (no wait)   | i_cfg_idx, i_cfg_data
//
// An item passes budget update, decision and result hand-off; when a backoff
// delay is drawn, it is random_byte mod (2^BE - 1), worked out one dividend bit
// per cycle in the remainder unit (8 steps) before the hand-off.
// o_stall is high from the cycle after accept until the result is loaded.
// A result waiting on i_stall does not block the next accept; that item is held
// at its last step until the result register frees up.
// Reset (synchronous, active low) clears the CSMA state, the budget and the
// configuration to their defaults. No clearing pass.
module slotted_csma_ca_backoff_unit #(
    parameter int MAX_SIFS_FRAME = csmabo_pkg::MAX_SIFS_FRAME_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration write port
    input  logic                                  i_cfg_we,
    input  logic [csmabo_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [csmabo_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // input items
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic                                  i_opcode,
    input  logic [csmabo_pkg::BUDGET_W-1:0]       i_cap_budget,
    input  logic                                  i_in_cap,
    input  logic                                  i_queue_nonempty,
    input  logic [csmabo_pkg::LEN_W-1:0]          i_frame_len,
    input  logic                                  i_ack_request,
    input  logic                                  i_channel_clear,
    input  logic [csmabo_pkg::RND_W-1:0]          i_random_byte,
    // result items
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic [1:0]                            o_action,
    output logic [csmabo_pkg::BUDGET_W-1:0]       o_budget_left
);

    csmabo_pkg::t_cmd w_cmd;
    csmabo_pkg::t_sts w_sts;

    // Controller: walks each item through budget update, decision,
    // optional delay draw and result hand-off.
    csmabo_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_busy     (o_stall)
    );

    // Datapath: holds config, CSMA state (phase, NB, BE, CW, delay, budget),
    // the remainder unit and the result register.
    csmabo_dp #(
        .MAX_SIFS_FRAME (MAX_SIFS_FRAME)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_opcode         (i_opcode),
        .i_cap_budget     (i_cap_budget),
        .i_in_cap         (i_in_cap),
        .i_queue_nonempty (i_queue_nonempty),
        .i_frame_len      (i_frame_len),
        .i_ack_request    (i_ack_request),
        .i_channel_clear  (i_channel_clear),
        .i_random_byte    (i_random_byte),
        .i_out_stall      (i_stall),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .o_out_valid      (o_valid),
        .o_action         (o_action),
        .o_budget_left    (o_budget_left)
    );

`ifndef SYNTHESIS
    // An accepted item keeps the input side closed on the next cycle.
    a_accept_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input not closed after accept");

    // A new result never overwrites one still waiting downstream.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.push |-> !(o_valid && i_stall))
        else $error("pending result overwritten");

    // Only defined actions leave the block.
    a_action_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_action == csmabo_pkg::ACT_NONE || o_action == csmabo_pkg::ACT_TX
                     || o_action == csmabo_pkg::ACT_FAIL))
        else $error("undefined action code");
`endif

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the slotted CSMA-CA backoff unit.
module tb_top;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE_TICKS = 16;   // longer than the delay-draw path
    localparam int PHASE_ITEMS  = 325;

    // One input item and one result item, at the port widths
    typedef struct {
        logic                            opcode;
        logic [csmabo_pkg::BUDGET_W-1:0] cap_budget;
        logic                            in_cap;
        logic                            queue_nonempty;
        logic [csmabo_pkg::LEN_W-1:0]    frame_len;
        logic                            ack_request;
        logic                            channel_clear;
        logic [csmabo_pkg::RND_W-1:0]    random_byte;
    } t_item;

    typedef struct {
        logic [1:0]                      action;
        logic [csmabo_pkg::BUDGET_W-1:0] budget_left;
    } t_result;

    // Directed stimulus: an item, or a register write done while idle
    typedef enum logic { ROW_ITEM, ROW_REG } t_row_kind;

    typedef struct {
        t_row_kind                          kind;
        logic [csmabo_pkg::CFG_IDX_W-1:0]   reg_idx;
        logic [csmabo_pkg::CFG_DATA_W-1:0]  reg_val;
        t_item                              item;
        logic                               typed;   // want holds a hand-written result
        t_result                            want;
    } t_dir_row;

    // DUT ports
    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               i_cfg_we = 1'b0;
    logic [csmabo_pkg::CFG_IDX_W-1:0]   i_cfg_idx = '0;
    logic [csmabo_pkg::CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                               i_valid = 1'b0;
    logic                               o_stall;
    logic                               i_opcode = csmabo_pkg::OP_TICK;
    logic [csmabo_pkg::BUDGET_W-1:0]    i_cap_budget = '0;
    logic                               i_in_cap = 1'b0;
    logic                               i_queue_nonempty = 1'b0;
    logic [csmabo_pkg::LEN_W-1:0]       i_frame_len = '0;
    logic                               i_ack_request = 1'b0;
    logic                               i_channel_clear = 1'b0;
    logic [csmabo_pkg::RND_W-1:0]       i_random_byte = '0;
    logic                               o_valid;
    logic                               i_stall = 1'b0;
    logic [1:0]                         o_action;
    logic [csmabo_pkg::BUDGET_W-1:0]    o_budget_left;

    // Shadow copy of the configuration registers
    logic [3:0]  cfg_min_be  = csmabo_pkg::MIN_BE_RST;
    logic [3:0]  cfg_max_be  = csmabo_pkg::MAX_BE_RST;
    logic [3:0]  cfg_max_nb  = csmabo_pkg::MAX_NB_RST;
    logic        cfg_ble     = 1'b0;
    logic [15:0] cfg_sifs    = '0;
    logic [15:0] cfg_lifs    = '0;
    logic [15:0] cfg_tick    = '0;
    logic [15:0] cfg_ack_ovh = '0;

    // Shadow CSMA state
    logic [1:0]                      mdl_phase  = csmabo_pkg::PH_INIT;
    logic [3:0]                      mdl_nb     = '0;
    logic [3:0]                      mdl_be     = '0;
    logic [1:0]                      mdl_cw     = '0;
    logic [7:0]                      mdl_delay  = '0;
    logic [csmabo_pkg::BUDGET_W-1:0] mdl_budget = '0;

    t_result due_results[$];
    int      err_cnt = 0;
    int      cycle_cnt = 0;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;

    slotted_csma_ca_backoff_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_opcode         (i_opcode),
        .i_cap_budget     (i_cap_budget),
        .i_in_cap         (i_in_cap),
        .i_queue_nonempty (i_queue_nonempty),
        .i_frame_len      (i_frame_len),
        .i_ack_request    (i_ack_request),
        .i_channel_clear  (i_channel_clear),
        .i_random_byte    (i_random_byte),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_action         (o_action),
        .o_budget_left    (o_budget_left)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Backoff delay: rnd mod (2^BE - 1), zero for BE 0 or 1
    function automatic logic [7:0] delay_draw(logic [3:0] be, logic [7:0] rnd);
        int unsigned span;
        if (be <= 4'd1) begin
            return 8'd0;
        end
        span = (32'd1 << be) - 32'd1;
        return 8'(32'(rnd) % span);
    endfunction

    // Advance the shadow CSMA machine by one item and return its result
    function automatic t_result backoff_step(t_item it);
        t_result      r;
        logic         run_cca;
        logic [63:0]  need;
        r.action = csmabo_pkg::ACT_NONE;
        run_cca  = 1'b0;
        need = 64'(it.frame_len) * 64'd2
             + (it.ack_request ? 64'(cfg_ack_ovh) : 64'd0)
             + ((it.frame_len < csmabo_pkg::MAX_SIFS_FRAME_DEF) ? 64'(cfg_sifs)
                                                                : 64'(cfg_lifs));
        if (it.opcode == csmabo_pkg::OP_LOAD) begin
            mdl_budget = it.cap_budget;
        end else if (it.in_cap) begin
            // budget is only charged when it covers a whole tick
            if (mdl_budget >= 32'(cfg_tick)) begin
                mdl_budget = mdl_budget - 32'(cfg_tick);
            end
            case (mdl_phase)
                csmabo_pkg::PH_DELAY: begin
                    if (mdl_delay == 8'd0) begin
                        if (need <= 64'(mdl_budget)) begin
                            mdl_phase = csmabo_pkg::PH_CCA;
                            run_cca   = 1'b1;
                        end else begin
                            mdl_delay = delay_draw(mdl_be, it.random_byte);
                        end
                    end else begin
                        mdl_delay = mdl_delay - 8'd1;
                    end
                end
                csmabo_pkg::PH_CCA: begin
                    run_cca = 1'b1;
                end
                default: begin
                    // init phase, and the unused code as well
                    if (it.queue_nonempty) begin
                        mdl_nb    = '0;
                        mdl_cw    = csmabo_pkg::CW_INIT;
                        mdl_be    = (cfg_ble && cfg_min_be > csmabo_pkg::BLE_BE)
                                    ? csmabo_pkg::BLE_BE : cfg_min_be;
                        mdl_delay = delay_draw(mdl_be, it.random_byte);
                        mdl_phase = csmabo_pkg::PH_DELAY;
                    end
                end
            endcase
            if (run_cca) begin
                if (!it.channel_clear) begin
                    mdl_cw = csmabo_pkg::CW_INIT;
                    if (mdl_nb > cfg_max_nb) begin
                        r.action  = csmabo_pkg::ACT_FAIL;
                        mdl_phase = csmabo_pkg::PH_INIT;
                    end else begin
                        mdl_nb = mdl_nb + 4'd1;
                        if (mdl_be < cfg_max_be) begin
                            mdl_be = mdl_be + 4'd1;
                        end
                        mdl_delay = delay_draw(mdl_be, it.random_byte);
                        mdl_phase = csmabo_pkg::PH_DELAY;
                    end
                end else begin
                    mdl_cw = mdl_cw - 2'd1;
                    if (mdl_cw == 2'd0) begin
                        r.action  = csmabo_pkg::ACT_TX;
                        mdl_phase = csmabo_pkg::PH_INIT;
                    end
                end
            end
        end
        r.budget_left = mdl_budget;
        return r;
    endfunction

    function automatic t_dir_row item_row(logic op, logic [csmabo_pkg::BUDGET_W-1:0] bud,
                                          logic cap, logic q,
                                          logic [csmabo_pkg::LEN_W-1:0] len, logic ack,
                                          logic clr, logic [csmabo_pkg::RND_W-1:0] rnd);
        t_dir_row row;
        row.kind                = ROW_ITEM;
        row.reg_idx             = csmabo_pkg::CFG_MIN_BE;
        row.reg_val             = '0;
        row.item.opcode         = op;
        row.item.cap_budget     = bud;
        row.item.in_cap         = cap;
        row.item.queue_nonempty = q;
        row.item.frame_len      = len;
        row.item.ack_request    = ack;
        row.item.channel_clear  = clr;
        row.item.random_byte    = rnd;
        row.typed               = 1'b0;
        row.want.action         = csmabo_pkg::ACT_NONE;
        row.want.budget_left    = '0;
        return row;
    endfunction

    function automatic t_dir_row reg_row(logic [csmabo_pkg::CFG_IDX_W-1:0] idx,
                                         logic [csmabo_pkg::CFG_DATA_W-1:0] val);
        t_dir_row row;
        row         = item_row(csmabo_pkg::OP_TICK, '0, 1'b0, 1'b0, '0, 1'b0, 1'b0, '0);
        row.kind    = ROW_REG;
        row.reg_idx = idx;
        row.reg_val = val;
        return row;
    endfunction

    function automatic t_dir_row with_expect(t_dir_row row, logic [1:0] act,
                                             logic [csmabo_pkg::BUDGET_W-1:0] bud);
        row.typed            = 1'b1;
        row.want.action      = act;
        row.want.budget_left = bud;
        return row;
    endfunction

    // Mostly in-CAP ticks with a waiting frame, so backoffs run to the end;
    // frame lengths lean on the SIFS/LIFS boundary, draws lean on short delays
    function automatic t_item rand_access_item();
        t_item it;
        it.opcode         = ($urandom_range(0, 99) < 4) ? csmabo_pkg::OP_LOAD
                                                        : csmabo_pkg::OP_TICK;
        it.cap_budget     = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 700))
                                                        : 32'($urandom());
        it.in_cap         = ($urandom_range(0, 99) < 88);
        it.queue_nonempty = ($urandom_range(0, 99) < 85);
        it.frame_len      = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(17, 18))
                                                        : 7'($urandom_range(0, 127));
        it.ack_request    = 1'($urandom_range(0, 1));
        it.channel_clear  = ($urandom_range(0, 99) < 65);
        it.random_byte    = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 15))
                                                        : 8'($urandom_range(0, 255));
        return it;
    endfunction

    // Drop valid and wait until every outstanding result has drained
    task automatic wait_results_done();
        i_valid <= 1'b0;
        while (due_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [csmabo_pkg::CFG_IDX_W-1:0] idx,
                             logic [csmabo_pkg::CFG_DATA_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            csmabo_pkg::CFG_MIN_BE:  cfg_min_be  = val[3:0];
            csmabo_pkg::CFG_MAX_BE:  cfg_max_be  = val[3:0];
            csmabo_pkg::CFG_MAX_NB:  cfg_max_nb  = val[3:0];
            csmabo_pkg::CFG_BLE:     cfg_ble     = val[0];
            csmabo_pkg::CFG_SIFS:    cfg_sifs    = val;
            csmabo_pkg::CFG_LIFS:    cfg_lifs    = val;
            csmabo_pkg::CFG_TICK:    cfg_tick    = val;
            csmabo_pkg::CFG_ACK_OVH: cfg_ack_ovh = val;
            default: ;
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic program_regs(logic [3:0] min_be, logic [3:0] max_be, logic [3:0] max_nb,
                                logic ble, logic [15:0] sifs, logic [15:0] lifs,
                                logic [15:0] tick, logic [15:0] ack_ovh);
        write_reg(csmabo_pkg::CFG_MIN_BE, 16'(min_be));
        write_reg(csmabo_pkg::CFG_MAX_BE, 16'(max_be));
        write_reg(csmabo_pkg::CFG_MAX_NB, 16'(max_nb));
        write_reg(csmabo_pkg::CFG_BLE, 16'(ble));
        write_reg(csmabo_pkg::CFG_SIFS, sifs);
        write_reg(csmabo_pkg::CFG_LIFS, lifs);
        write_reg(csmabo_pkg::CFG_TICK, tick);
        write_reg(csmabo_pkg::CFG_ACK_OVH, ack_ovh);
    endtask

    // Present one item, hold it until accepted, then log its expected result
    task automatic send_item(t_item it, logic typed, t_result want);
        t_result r;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_opcode         <= it.opcode;
        i_cap_budget     <= it.cap_budget;
        i_in_cap         <= it.in_cap;
        i_queue_nonempty <= it.queue_nonempty;
        i_frame_len      <= it.frame_len;
        i_ack_request    <= it.ack_request;
        i_channel_clear  <= it.channel_clear;
        i_random_byte    <= it.random_byte;
        do begin
            @(posedge i_clk);
        end while (o_stall);
        r = backoff_step(it);
        if (typed) begin
            due_results.push_back(want);
        end else begin
            due_results.push_back(r);
        end
    endtask

    // Receiver back-pressure
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // Result checker
    always @(posedge i_clk) begin : check_results
        t_result exp_r;
        if (i_rst_n && o_valid && !i_stall) begin
            if (due_results.size() == 0) begin
                $error("result with none pending: action %0d budget_left %0h",
                       o_action, o_budget_left);
                err_cnt++;
            end else begin
                exp_r = due_results.pop_front();
                if (o_action !== exp_r.action) begin
                    $error("action: expected %0d, got %0d", exp_r.action, o_action);
                    err_cnt++;
                end
                if (o_budget_left !== exp_r.budget_left) begin
                    $error("budget_left: expected %0h, got %0h",
                           exp_r.budget_left, o_budget_left);
                    err_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    initial begin : stimulus
        t_dir_row rows[$];
        t_result  no_want;
        no_want.action      = csmabo_pkg::ACT_NONE;
        no_want.budget_left = '0;

        // after reset: nothing to do, nothing outside the CAP, then a budget load
        rows.push_back(with_expect(item_row(csmabo_pkg::OP_TICK, '0, 1, 0, 0, 0, 1, 0),
                                   csmabo_pkg::ACT_NONE, '0));
        rows.push_back(with_expect(item_row(csmabo_pkg::OP_TICK, 32'hFFFF_FFFF, 0, 1, 127,
                                            1, 0, 8'hFF),
                                   csmabo_pkg::ACT_NONE, '0));
        rows.push_back(with_expect(item_row(csmabo_pkg::OP_LOAD, 32'hFFFF_FFFF, 0, 0, 0,
                                            0, 0, 0),
                                   csmabo_pkg::ACT_NONE, 32'hFFFF_FFFF));
        // full backoff: draw, count down, busy CCA, two clear CCAs, transmit
        rows.push_back(reg_row(csmabo_pkg::CFG_TICK, 16'hFFFF));
        rows.push_back(item_row(csmabo_pkg::OP_TICK, '0, 1, 1, 127, 1, 1, 8'hFF));
        repeat (3) rows.push_back(item_row(csmabo_pkg::OP_TICK, '0, 1, 1, 127, 1, 1, 8'h00));
        rows.push_back(item_row(csmabo_pkg::OP_TICK, '0, 1, 1, 127, 1, 0, 8'h00));
        repeat (2) rows.push_back(item_row(csmabo_pkg::OP_TICK, '0, 1, 1, 0, 0, 1, 8'h00));
        // max NB of zero: first busy CCA backs off again, second busy CCA drops the frame
        rows.push_back(reg_row(csmabo_pkg::CFG_MIN_BE, 16'h0));
        rows.push_back(reg_row(csmabo_pkg::CFG_MAX_NB, 16'h0));
        rows.push_back(item_row(csmabo_pkg::OP_TICK, '0, 1, 1, 5, 0, 1, 8'h00));
        repeat (2) rows.push_back(item_row(csmabo_pkg::OP_TICK, '0, 1, 1, 5, 0, 0, 8'hA5));
        // budget below one tick stays put; frame does not fit and redraws
        rows.push_back(with_expect(item_row(csmabo_pkg::OP_LOAD, 32'd5, 1, 1, 0, 0, 0, 0),
                                   csmabo_pkg::ACT_NONE, 32'd5));
        rows.push_back(with_expect(item_row(csmabo_pkg::OP_TICK, '0, 1, 1, 127, 1, 1,
                                            8'h00),
                                   csmabo_pkg::ACT_NONE, 32'd5));
        rows.push_back(item_row(csmabo_pkg::OP_TICK, '0, 1, 1, 127, 1, 1, 8'h33));
        // long-IFS side too big, exact fit on the short-IFS side, then
        // battery-life mode capping a large min BE
        rows.push_back(reg_row(csmabo_pkg::CFG_TICK, 16'h0));
        rows.push_back(reg_row(csmabo_pkg::CFG_MIN_BE, 16'hF));
        rows.push_back(reg_row(csmabo_pkg::CFG_MAX_BE, 16'hF));
        rows.push_back(reg_row(csmabo_pkg::CFG_BLE, 16'h1));
        rows.push_back(reg_row(csmabo_pkg::CFG_LIFS, 16'hFFFF));
        rows.push_back(with_expect(item_row(csmabo_pkg::OP_LOAD, 32'd34, 0, 0, 0, 0, 0, 0),
                                   csmabo_pkg::ACT_NONE, 32'd34));
        rows.push_back(item_row(csmabo_pkg::OP_TICK, '0, 1, 1, 18, 0, 1, 8'h00));
        repeat (2) rows.push_back(item_row(csmabo_pkg::OP_TICK, '0, 1, 1, 17, 0, 1, 8'h00));
        rows.push_back(item_row(csmabo_pkg::OP_TICK, '0, 1, 1, 17, 0, 1, 8'hFF));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 16;
        recv_idle_pct = 68;
        foreach (rows[k]) begin
            if (rows[k].kind == ROW_REG) begin
                wait_results_done();
                write_reg(rows[k].reg_idx, rows[k].reg_val);
            end else begin
                send_item(rows[k].item, rows[k].typed, rows[k].want);
            end
        end

        // random phases, each under its own configuration
        for (int ph = 0; ph < 6; ph++) begin
            wait_results_done();
            case (ph)
                0: program_regs(4'd3, 4'd5, 4'd4, 1'b0, 16'd12, 16'd40, 16'd20, 16'd22);
                1: program_regs(4'd0, 4'd15, 4'd15, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0);
                2: program_regs(4'd15, 4'd15, 4'd0, 1'b1, 16'hFFFF, 16'hFFFF,
                                16'hFFFF, 16'hFFFF);
                3: program_regs(4'd2, 4'd3, 4'd1, 1'b1, 16'($urandom_range(0, 300)),
                                16'($urandom_range(0, 300)), 16'($urandom_range(0, 300)),
                                16'($urandom_range(0, 300)));
                4: program_regs(4'($urandom_range(0, 4)), 4'($urandom_range(0, 6)),
                                4'($urandom_range(0, 5)), 1'($urandom_range(0, 1)),
                                16'($urandom()), 16'($urandom()), 16'($urandom()),
                                16'($urandom()));
                default: program_regs(4'd15, 4'd15, 4'd15, 1'b0, 16'd7, 16'd9,
                                      16'd1, 16'd0);
            endcase
            send_idle_pct = (ph < 2) ? 16 : (ph < 4) ? 68 : 0;
            recv_idle_pct = (ph < 2) ? 68 : (ph < 4) ? 16 : 0;
            repeat (PHASE_ITEMS) begin
                // now and then hold off until the block has fully drained
                if ($urandom_range(0, 199) == 0) begin
                    wait_results_done();
                end
                send_item(rand_access_item(), 1'b0, no_want);
            end
        end

        wait_results_done();
        if (err_cnt == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

FILE: filelist.f
design/csmabo_pkg.sv
design/csmabo_ctrl.sv
design/csmabo_dp.sv
design/slotted_csma_ca_backoff_unit.sv
tb/tb_top.sv
